@@ hw/rtl/tfclf_pkg.sv @@
// Shared types and constants for the telnet filter command line framer.
// Holds the result item layout, result kinds and telnet byte codes.
// No dependencies.
package tfclf_pkg;

  localparam int unsigned CFG_W      = 13;
  localparam int unsigned OQ_DEPTH   = 4;
  localparam int unsigned OQ_PTR_W   = 2;
  localparam int unsigned OQ_CNT_W   = 3;

  localparam logic [CFG_W-1:0] MAX_LINE_LEN_RESET = 13'd1024;
  localparam logic             ADDR_MAX_LINE_LEN  = 1'b0;

  localparam logic [7:0] TEL_IAC  = 8'hFF;
  localparam logic [7:0] TEL_DONT = 8'hFE;
  localparam logic [7:0] TEL_DO   = 8'hFD;
  localparam logic [7:0] TEL_WONT = 8'hFC;
  localparam logic [7:0] TEL_WILL = 8'hFB;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] KIND_CHAR    = 3'd0;
  localparam logic [2:0] KIND_EOL     = 3'd1;
  localparam logic [2:0] KIND_REPLY   = 3'd2;
  localparam logic [2:0] KIND_NUL_ERR = 3'd3;
  localparam logic [2:0] KIND_OVF     = 3'd4;

  localparam logic VERB_DONT = 1'b0;
  localparam logic VERB_WONT = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] line_char;
    logic       verb;
    logic [7:0] option;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]       cnt;
    res_t [1:0]       items;
  } push_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] ch, logic verb,
                                  logic [7:0] opt);
    res_t r;
    r.kind      = kind;
    r.line_char = ch;
    r.verb      = verb;
    r.option    = opt;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

@@ hw/rtl/tfclf_filter.sv @@
// Per-byte telnet filter and line stage with its state registers.
// Produces up to two result items per accepted byte. Depends on tfclf_pkg.
module tfclf_filter #(
  parameter int unsigned LINE_LIMIT_MAX = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      acc,
  input  logic [7:0]                rx_byte,
  input  logic [tfclf_pkg::CFG_W-1:0] max_line_len,
  output tfclf_pkg::push_t          push
);
  import tfclf_pkg::*;

  localparam int unsigned LW = $clog2(LINE_LIMIT_MAX + 1);
  localparam int unsigned CW = (LW > CFG_W) ? LW : CFG_W;

  typedef enum logic [1:0] {
    PH_DATA = 2'd0,
    PH_CMD  = 2'd1,
    PH_OPT  = 2'd2
  } phase_t;

  phase_t        phase, phase_next;
  logic          pending_verb, pending_verb_next;
  logic          cr_held, cr_held_next;
  logic [LW-1:0] line_count, line_count_next;
  logic          halted, halted_next;

  logic [CW-1:0] ml_ext;
  logic [CW-1:0] limit;
  logic [CW:0]   count_inc;
  logic          line_go;

  assign ml_ext    = CW'(max_line_len);
  assign count_inc = (CW + 1)'(line_count) + (CW + 1)'(1);

  always_comb begin
    if (ml_ext < CW'(2)) begin
      limit = CW'(2);
    end else if (ml_ext > CW'(LINE_LIMIT_MAX)) begin
      limit = CW'(LINE_LIMIT_MAX);
    end else begin
      limit = ml_ext;
    end
  end

  always_comb begin
    phase_next        = phase;
    pending_verb_next = pending_verb;
    cr_held_next      = cr_held;
    line_count_next   = line_count;
    halted_next       = halted;
    line_go           = 1'b0;
    push              = '0;

    if (acc && !halted) begin
      unique case (phase)
        PH_CMD: begin
          phase_next = PH_DATA;
          if (rx_byte == TEL_IAC) begin
            line_go = 1'b1;
          end else if (rx_byte == TEL_WILL || rx_byte == TEL_WONT) begin
            pending_verb_next = VERB_DONT;
            phase_next        = PH_OPT;
          end else if (rx_byte == TEL_DO || rx_byte == TEL_DONT) begin
            pending_verb_next = VERB_WONT;
            phase_next        = PH_OPT;
          end
        end
        PH_OPT: begin
          phase_next     = PH_DATA;
          push.cnt       = 2'd1;
          push.items[0]  = mk_res(KIND_REPLY, 8'h00, pending_verb, rx_byte);
        end
        default: begin
          phase_next = PH_DATA;
          if (rx_byte == TEL_IAC) begin
            phase_next = PH_CMD;
          end else begin
            line_go = 1'b1;
          end
        end
      endcase
    end

    if (line_go) begin
      if (cr_held && rx_byte == CH_LF) begin
        cr_held_next    = 1'b0;
        line_count_next = '0;
        push.cnt        = 2'd1;
        push.items[0]   = mk_res(KIND_EOL, 8'h00, 1'b0, 8'h00);
      end else if (!cr_held && rx_byte == CH_NUL) begin
        halted_next   = 1'b1;
        push.cnt      = 2'd1;
        push.items[0] = mk_res(KIND_NUL_ERR, 8'h00, 1'b0, 8'h00);
      end else if (count_inc >= (CW + 1)'(limit)) begin
        halted_next   = 1'b1;
        push.cnt      = 2'd1;
        push.items[0] = mk_res(KIND_OVF, 8'h00, 1'b0, 8'h00);
      end else begin
        line_count_next = count_inc[LW-1:0];
        if (cr_held) begin
          push.items[0] = mk_res(KIND_CHAR, CH_CR, 1'b0, 8'h00);
          if (rx_byte == CH_CR) begin
            cr_held_next = 1'b1;
            push.cnt     = 2'd1;
          end else if (rx_byte == CH_NUL) begin
            cr_held_next = 1'b0;
            push.cnt     = 2'd1;
          end else begin
            cr_held_next  = 1'b0;
            push.cnt      = 2'd2;
            push.items[1] = mk_res(KIND_CHAR, rx_byte, 1'b0, 8'h00);
          end
        end else if (rx_byte == CH_CR) begin
          cr_held_next = 1'b1;
        end else begin
          push.cnt      = 2'd1;
          push.items[0] = mk_res(KIND_CHAR, rx_byte, 1'b0, 8'h00);
        end
      end
    end

    if (push.cnt == 2'd1) begin
      push.items[0].last = 1'b1;
    end else if (push.cnt == 2'd2) begin
      push.items[1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DATA;
      pending_verb <= 1'b0;
      cr_held      <= 1'b0;
      line_count   <= '0;
      halted       <= 1'b0;
    end else begin
      phase        <= phase_next;
      pending_verb <= pending_verb_next;
      cr_held      <= cr_held_next;
      line_count   <= line_count_next;
      halted       <= halted_next;
    end
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted cleared without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> push.cnt == 2'd0)
    else $error("result produced while halted");

  a_reply_phase: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0 && push.items[0].kind == KIND_REPLY) |->
      (phase == PH_OPT && push.cnt == 2'd1))
    else $error("telnet reply outside option phase");

endmodule

@@ hw/rtl/tfclf_outq.sv @@
// Small result queue that takes up to two items per cycle and gives one when the output is ready.
// Decouples the filter from output stalls. Depends on tfclf_pkg.
module tfclf_outq (
  input  logic              clk,
  input  logic              rst,
  input  tfclf_pkg::push_t  push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output tfclf_pkg::res_t   head
);
  import tfclf_pkg::*;

  res_t                mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_CNT_W-1:0] count;
  logic                pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.items[0];
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + OQ_PTR_W'(1)] <= push.items[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push.cnt);
      rd_ptr <= rd_ptr + OQ_PTR_W'(pop);
      count  <= count + OQ_CNT_W'(push.cnt) - OQ_CNT_W'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    count <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overrun");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> (count + OQ_CNT_W'(push.cnt) - OQ_CNT_W'(pop))
                         <= OQ_CNT_W'(OQ_DEPTH))
    else $error("push without room");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[OQ_PTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

@@ hw/rtl/telnet_filter_command_line_framer.sv @@
// Top level of the telnet filter command line framer.
// Holds the APB register and ties the filter to the result queue.
// Depends on tfclf_pkg, tfclf_filter and tfclf_outq.

// Each received byte yields zero, one or two result items; a new byte is
// accepted every cycle while the four-entry result queue has room for two
// more items, so bytes that give one item each stream at one per cycle
// while the output is ready, and bytes that give two are limited by the
// single output port. After an illegal NUL or a line overflow the block
// keeps accepting bytes but gives no further items until reset.
module telnet_filter_command_line_framer #(
  parameter int unsigned LINE_LIMIT_MAX = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [7:0]  line_char,
  output logic        reply_verb,
  output logic [7:0]  reply_option,
  output logic        last_of_run
);
  import tfclf_pkg::*;

  logic [CFG_W-1:0] max_line_len;
  logic             acc;
  logic             room;
  push_t            push;
  res_t             head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_MAX_LINE_LEN) ?
                  {{(32 - CFG_W){1'b0}}, max_line_len} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_len <= MAX_LINE_LEN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ADDR_MAX_LINE_LEN) begin
      max_line_len <= pwdata[CFG_W-1:0];
    end
  end

  assign in_ready = room;
  assign acc      = in_valid && in_ready;

  tfclf_filter #(
    .LINE_LIMIT_MAX(LINE_LIMIT_MAX)
  ) u_filter (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .rx_byte     (rx_byte),
    .max_line_len(max_line_len),
    .push        (push)
  );

  tfclf_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign result_kind  = head.kind;
  assign line_char    = head.line_char;
  assign reply_verb   = head.verb;
  assign reply_option = head.option;
  assign last_of_run  = head.last;

endmodule

@@ dv/tb_telnet_filter_command_line_framer.sv @@
// Self-checking testbench for the telnet filter command line framer.
// Drives received bytes and APB writes, predicts result items with a scoreboard class.
// Depends on tfclf_pkg and telnet_filter_command_line_framer.
`timescale 1ns / 100ps

module tb_telnet_filter_command_line_framer;
  import tfclf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE = 8;
  localparam int unsigned NUM_PHASES = 11;
  localparam int unsigned ITEMS_PER_PHASE = 86;
  localparam int unsigned LIMIT_CLAMP = 4096;
  localparam logic [2:0] ADDR_LIMIT = {ADDR_MAX_LINE_LEN, 2'b00};
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam logic [7:0] TEL_NOP = 8'hF1;

  localparam logic [7:0] OPENING [28] = '{
    8'h80, 8'h7F, CH_LF, CH_CR, TEL_IAC, TEL_DO, 8'h00, CH_LF,
    TEL_IAC, TEL_IAC, TEL_IAC, TEL_WILL, 8'hFF, TEL_IAC, TEL_WONT, 8'h01,
    TEL_IAC, TEL_DONT, 8'h18, TEL_IAC, TEL_NOP, CH_CR, CH_NUL, CH_CR,
    8'h78, CH_CR, CH_CR, CH_LF
  };

  typedef enum logic [1:0] {PH_DATA, PH_CMD, PH_OPT} tel_phase_t;
  typedef enum int {
    HALT_LONE_NUL, HALT_NUL_AT_LIMIT, HALT_CR_THEN_OVF, HALT_LOWERED
  } halt_mode_t;

  class line_framer_scoreboard;
    logic [12:0] limit_reg;
    tel_phase_t phase;
    logic pending_verb;
    bit cr_held;
    int unsigned line_count;
    bit halted;
    res_t staged [2];
    int staged_n;
    res_t expected_q [$];
    int errors;

    function new();
      reset_state();
      errors = 0;
    endfunction

    function void reset_state();
      limit_reg = MAX_LINE_LEN_RESET;
      phase = PH_DATA;
      pending_verb = VERB_DONT;
      cr_held = 0;
      line_count = 0;
      halted = 0;
      staged_n = 0;
    endfunction

    function void write_limit(logic [12:0] value);
      limit_reg = value;
    endfunction

    function int unsigned eff_limit();
      int unsigned l;
      l = limit_reg;
      if (l < 2) l = 2;
      if (l > LIMIT_CLAMP) l = LIMIT_CLAMP;
      return l;
    endfunction

    function void push(logic [2:0] kind, logic [7:0] ch, logic verb, logic [7:0] opt);
      staged[staged_n].kind = kind;
      staged[staged_n].line_char = ch;
      staged[staged_n].verb = verb;
      staged[staged_n].option = opt;
      staged[staged_n].last = 1'b0;
      staged_n++;
    endfunction

    function void line_stage(logic [7:0] c);
      if (cr_held && c == CH_LF) begin
        cr_held = 0;
        line_count = 0;
        push(KIND_EOL, 8'h00, 1'b0, 8'h00);
        return;
      end
      if (!cr_held && c == CH_NUL) begin
        halted = 1;
        push(KIND_NUL_ERR, 8'h00, 1'b0, 8'h00);
        return;
      end
      if (line_count + 1 >= eff_limit()) begin
        halted = 1;
        push(KIND_OVF, 8'h00, 1'b0, 8'h00);
        return;
      end
      line_count++;
      if (cr_held) begin
        push(KIND_CHAR, CH_CR, 1'b0, 8'h00);
        cr_held = 0;
        if (c == CH_NUL) return;
      end
      if (c == CH_CR) cr_held = 1;
      else push(KIND_CHAR, c, 1'b0, 8'h00);
    endfunction

    function void advance(logic [7:0] c);
      staged_n = 0;
      if (halted) return;
      unique case (phase)
        PH_CMD: begin
          if (c == TEL_IAC) begin
            phase = PH_DATA;
            line_stage(c);
          end else if (c == TEL_WILL || c == TEL_WONT) begin
            pending_verb = VERB_DONT;
            phase = PH_OPT;
          end else if (c == TEL_DO || c == TEL_DONT) begin
            pending_verb = VERB_WONT;
            phase = PH_OPT;
          end else begin
            phase = PH_DATA;
          end
        end
        PH_OPT: begin
          phase = PH_DATA;
          push(KIND_REPLY, 8'h00, pending_verb, c);
        end
        default: begin
          phase = PH_DATA;
          if (c == TEL_IAC) phase = PH_CMD;
          else line_stage(c);
        end
      endcase
      if (staged_n > 0) staged[staged_n-1].last = 1'b1;
    endfunction

    // A byte is safe when it does not halt the block and the line can still be closed.
    function bit safe_byte(logic [7:0] c);
      tel_phase_t s_phase;
      logic s_verb;
      bit s_cr;
      bit s_halt;
      int unsigned s_count;
      bit ok;
      s_phase = phase;
      s_verb = pending_verb;
      s_cr = cr_held;
      s_halt = halted;
      s_count = line_count;
      advance(c);
      ok = !halted && (cr_held || line_count + 1 < eff_limit());
      phase = s_phase;
      pending_verb = s_verb;
      cr_held = s_cr;
      halted = s_halt;
      line_count = s_count;
      staged_n = 0;
      return ok;
    endfunction

    function logic [7:0] rescue_byte();
      if (phase == PH_CMD) return TEL_NOP;
      if (phase == PH_OPT) return 8'($urandom_range(0, 255));
      if (cr_held) return CH_LF;
      return CH_CR;
    endfunction

    function bit line_closed();
      return phase == PH_DATA && !cr_held && line_count == 0;
    endfunction

    function bit idle();
      return expected_q.size() == 0;
    endfunction

    function void note_input(logic [7:0] c);
      advance(c);
      for (int i = 0; i < staged_n; i++) expected_q.push_back(staged[i]);
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: kind %0d char %02h", got.kind, got.line_char);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.kind !== exp_r.kind) begin
        $error("result_kind: expected %0d, got %0d", exp_r.kind, got.kind);
        errors++;
      end
      if (got.line_char !== exp_r.line_char) begin
        $error("line_char: expected %02h, got %02h", exp_r.line_char, got.line_char);
        errors++;
      end
      if (got.verb !== exp_r.verb) begin
        $error("reply_verb: expected %0d, got %0d", exp_r.verb, got.verb);
        errors++;
      end
      if (got.option !== exp_r.option) begin
        $error("reply_option: expected %02h, got %02h", exp_r.option, got.option);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last_of_run: expected %0d, got %0d", exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_ready;
  logic [2:0] result_kind;
  logic [7:0] line_char;
  logic reply_verb;
  logic [7:0] reply_option;
  logic last_of_run;
  bit calm;

  line_framer_scoreboard sb = new();
  logic [7:0] plan_q [$];

  telnet_filter_command_line_framer dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .line_char(line_char),
    .reply_verb(reply_verb),
    .reply_option(reply_option),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    res_t got;
    int stall;
    bit took;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      took = !rst && out_valid && out_ready;
      got.kind = result_kind;
      got.line_char = line_char;
      got.verb = reply_verb;
      got.option = reply_option;
      got.last = last_of_run;
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if (took) begin
        #1;
        sb.check_result(got);
      end
    end
  end

  task automatic send_item(input logic [7:0] c);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_byte <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(c);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (!sb.idle()) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [12:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= ($urandom() & ~32'h1FFF) | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LIMIT) sb.write_limit(value);
  endtask

  task automatic close_line();
    while (!sb.line_closed()) send_item(sb.rescue_byte());
  endtask

  function automatic void fill_plan();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if ($urandom_range(0, 9) < 7) plan_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      else plan_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 50) begin
      plan_q.push_back(CH_CR);
      plan_q.push_back(CH_LF);
    end else if (pick < 56) begin
      plan_q.push_back(CH_CR);
      plan_q.push_back(CH_NUL);
    end else if (pick < 62) begin
      plan_q.push_back(CH_CR);
      plan_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 70) begin
      plan_q.push_back(TEL_IAC);
      plan_q.push_back(TEL_IAC);
    end else if (pick < 85) begin
      plan_q.push_back(TEL_IAC);
      plan_q.push_back(8'(TEL_WILL + $urandom_range(0, 3)));
      plan_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      plan_q.push_back(TEL_IAC);
      plan_q.push_back(8'($urandom_range(0, 8'hFA)));
    end else begin
      plan_q.push_back(8'($urandom_range(0, 255)));
      plan_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic logic [7:0] next_byte();
    logic [7:0] c;
    if (plan_q.size() == 0) fill_plan();
    c = plan_q.pop_front();
    if (!sb.safe_byte(c)) begin
      c = sb.rescue_byte();
      plan_q.delete();
    end
    return c;
  endfunction

  initial begin
    logic [12:0] limit_sched [NUM_PHASES];
    halt_mode_t mode;
    limit_sched = '{13'd1024, 13'd0, 13'd3, 13'd8191, 13'd40, 13'd1, 13'd4096, 13'd2,
                    13'd4097, 13'd9, 13'd5};
    limit_sched[NUM_PHASES-1] = 13'($urandom_range(5, 30));
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (OPENING[i]) send_item(OPENING[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        close_line();
        wait_drained();
        write_reg(ADDR_LIMIT, limit_sched[ph]);
        if (ph == 3) write_reg(ADDR_UNUSED, 13'($urandom_range(0, 8191)));
      end
      calm = (ph == NUM_PHASES - 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 4 && i == ITEMS_PER_PHASE / 2) wait_drained();
        send_item(next_byte());
      end
    end

    // Finish with one halting error, then bytes that must be ignored.
    close_line();
    mode = halt_mode_t'($urandom_range(0, 3));
    unique case (mode)
      HALT_LONE_NUL: begin
        send_item(8'h71);
        send_item(CH_NUL);
      end
      HALT_NUL_AT_LIMIT: begin
        wait_drained();
        write_reg(ADDR_LIMIT, 13'd5);
        send_item(8'h61);
        send_item(8'h62);
        send_item(8'h63);
        send_item(CH_NUL);
      end
      HALT_CR_THEN_OVF: begin
        wait_drained();
        write_reg(ADDR_LIMIT, 13'd5);
        send_item(8'h61);
        send_item(8'h62);
        send_item(CH_CR);
        send_item(8'h64);
        send_item(8'h65);
      end
      default: begin
        wait_drained();
        write_reg(ADDR_LIMIT, 13'd1024);
        for (int i = 0; i < 6; i++) send_item(8'(8'h61 + i));
        wait_drained();
        write_reg(ADDR_LIMIT, 13'd4);
        send_item(8'h67);
      end
    endcase
    repeat (12) send_item(8'($urandom_range(0, 255)));

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tfclf_pkg.sv
hw/rtl/tfclf_filter.sv
hw/rtl/tfclf_outq.sv
hw/rtl/telnet_filter_command_line_framer.sv
dv/tb_telnet_filter_command_line_framer.sv
